// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the slot allocator modules.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hdl/dsa_pkg.sv -----
// Shared types and constants of the descriptor slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps

package dsa_pkg;

   localparam int DSA_SLOTS   = 32;
   localparam int CHUNK_BITS  = 32;
   localparam int TYPE_W      = 4;
   localparam int REQ_TUSER_W = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RESULT_W    = 11;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 24 - RESULT_W;

   localparam logic [RESULT_W-1:0] ALLOC_BASE = 11'd1024;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_OTHER = 2'd3
   } cmd_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic search_step;
      logic commit;
   } dsa_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      cmd_type req_cmd;
      cmd_type cur_cmd;
      logic    found;
      logic    last_chunk;
      logic    out_free;
   } dsa_sts_type;

endpackage

// ----- hdl/descriptor_slot_allocator.sv -----
// Channel   Dir  tuser    tdata fields, lowest bit first
// req_*     in   command  ds_type, slot_index, request_id, opaque_tag, opcode_in
// rsp_*     out  -        resp_id, resp_opaque, resp_opcode, result_value
//
// An allocate holds the block while it is accepted, searched one 32-slot chunk at a time until
// a free slot turns up or the last chunk is searched, and committed; its response is registered
// at the commit. A deallocate holds it while it is accepted and then committed, and an ignored
// command only while it is accepted.
// Reset is synchronous and clears all busy bits at once; the type store is not cleared.
// A stalled response waits in the output register while the next request is taken; that
// request then waits to commit, and no further request is accepted until it does.
// Top level of the descriptor slot allocator; depends on dsa_pkg, dsa_ctrl and dsa_datapath.
`timescale 1ns / 1ps

module descriptor_slot_allocator
   import dsa_pkg::*;
#(
   parameter int SLOTS = DSA_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // command[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // ds_type[3:0], slot_index[8:4], request_id[16:9], opaque_tag[24:17],
   // opcode_in[32:25], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // resp_id[7:0], resp_opaque[15:8], resp_opcode[23:16], result_value[34:24],
   // zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   dsa_cmd_type cmd;
   dsa_sts_type sts;

   dsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dsa_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hdl/dsa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module dsa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dsa_datapath.sv -----
// Datapath of the slot allocator: request registers, busy bitmap, chunked
// first-free search, type store and output register. Depends on dsa_pkg and dsa_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsa_datapath
   import dsa_pkg::*;
#(
   parameter int SLOTS = DSA_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dsa_cmd_type            cmd,
   output dsa_sts_type            sts,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int NumChunks = (SLOTS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int ChunkW    = (NumChunks > 1) ? $clog2(NumChunks) : 1;
   localparam int PadBits   = NumChunks * CHUNK_BITS;
   localparam int PosW      = $clog2(CHUNK_BITS);
   localparam int IdxW      = ChunkW + PosW;
   localparam int SlotW     = $clog2(SLOTS);

   cmd_type               command_ff;
   logic [TYPE_W-1:0]     ds_type_ff;
   logic [4:0]            slot_index_ff;
   logic [7:0]            request_id_ff;
   logic [7:0]            opaque_tag_ff;
   logic [7:0]            opcode_in_ff;

   logic [ChunkW-1:0]     chunk_ff;
   logic [ChunkW-1:0]     chunk_in;
   logic                  hit_ff;
   logic                  hit_in;
   logic [SlotW-1:0]      slot_ff;
   logic [SlotW-1:0]      slot_in;
   logic [SLOTS-1:0]      busy_ff;
   logic [SLOTS-1:0]      busy_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [SlotW-1:0]      last_addr_ff;
   logic [TYPE_W-1:0]     last_type_ff;
   logic                  written_ff;

   logic [PadBits-1:0]    busy_pad;
   logic [CHUNK_BITS-1:0] chunk_bits;
   logic                  enc_hit;
   logic [PosW-1:0]       enc_pos;
   logic [IdxW-1:0]       found_idx;
   logic                  last_chunk;
   logic                  alloc_hit;
   logic                  ram_wen;
   logic [TYPE_W-1:0]     ram_rdata;
   logic [RESULT_W-1:0]   result_value;

   // Padding slots past the end read as busy so they are never picked.
   for (genvar g = 0; g < PadBits; g++) begin : g_pad
      if (g < SLOTS) begin : g_real
         assign busy_pad[g] = busy_ff[g];
      end else begin : g_fill
         assign busy_pad[g] = 1'b1;
      end
   end

   assign chunk_bits = busy_pad[chunk_ff * CHUNK_BITS +: CHUNK_BITS];

   // Lowest clear bit of the current chunk.
   always_comb begin
      enc_hit = 1'b0;
      enc_pos = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         if (!chunk_bits[i]) begin
            enc_hit = 1'b1;
            enc_pos = PosW'(i);
         end
      end
   end

   assign found_idx  = {chunk_ff, enc_pos};
   assign last_chunk = (chunk_ff == ChunkW'(NumChunks - 1));
   assign alloc_hit  = (command_ff == CMD_ALLOC) && hit_ff;
   assign ram_wen    = cmd.commit && alloc_hit;

   always_comb begin
      chunk_in = chunk_ff;
      hit_in   = hit_ff;
      slot_in  = slot_ff;
      if (cmd.load_req) begin
         chunk_in = '0;
         hit_in   = 1'b0;
      end else if (cmd.search_step) begin
         if (enc_hit) begin
            hit_in  = 1'b1;
            slot_in = found_idx[SlotW-1:0];
         end else if (!last_chunk) begin
            chunk_in = chunk_ff + 1'b1;
         end
      end
   end

   // A free naming a slot past the end matches no bit here and changes nothing.
   always_comb begin
      busy_in = busy_ff;
      for (int i = 0; i < SLOTS; i++) begin
         if (ram_wen && (slot_ff == SlotW'(i))) begin
            busy_in[i] = 1'b1;
         end
         if (cmd.commit && (command_ff == CMD_FREE) && (32'(slot_index_ff) == i)) begin
            busy_in[i] = 1'b0;
         end
      end
   end

   assign result_value = alloc_hit ? (ALLOC_BASE + RESULT_W'(slot_ff)) : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= '0;
         hit_ff       <= 1'b0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= 1'b0;
      end else begin
         chunk_ff     <= chunk_in;
         hit_ff       <= hit_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wen) begin
            written_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.load_req) begin
         command_ff    <= cmd_type'(req_tuser);
         ds_type_ff    <= req_tdata[3:0];
         slot_index_ff <= req_tdata[8:4];
         request_id_ff <= req_tdata[16:9];
         opaque_tag_ff <= req_tdata[24:17];
         opcode_in_ff  <= req_tdata[32:25];
      end
      if (cmd.commit) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, result_value, opcode_in_ff,
                         opaque_tag_ff, request_id_ff};
      end
      if (ram_wen) begin
         last_addr_ff <= slot_ff;
         last_type_ff <= ds_type_ff;
      end
   end

   dsa_ram #(
      .WIDTH (TYPE_W),
      .DEPTH (SLOTS)
   ) u_type_ram (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (slot_ff),
      .wr_data (ds_type_ff),
      .rd_addr (last_addr_ff),
      .rd_data (ram_rdata)
   );

   assign sts.req_cmd    = cmd_type'(req_tuser);
   assign sts.cur_cmd    = command_ff;
   assign sts.found      = enc_hit;
   assign sts.last_chunk = last_chunk;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_alloc_slot_free, clock, reset, ram_wen, !busy_ff[slot_ff], "allocated slot was already busy")
   `ASSERT_IMPLIES(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff), $past(cmd.commit), "response beat without commit")
   `ASSERT_IMPLIES(a_type_readback, clock, reset, written_ff && !$past(ram_wen), ram_rdata == last_type_ff, "type store lost the last written code")

endmodule

// ----- hdl/dsa_ctrl.sv -----
// Controller state machine of the slot allocator: accepts a request beat,
// steps the chunk search and commits the response. Depends on dsa_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsa_ctrl
   import dsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dsa_sts_type sts,
   output dsa_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_RESP   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in        = state_ff;
      req_tready      = 1'b0;
      cmd.load_req    = 1'b0;
      cmd.search_step = 1'b0;
      cmd.commit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               case (sts.req_cmd)
                  CMD_ALLOC: state_in = ST_SEARCH;
                  CMD_FREE:  state_in = ST_RESP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.found || sts.last_chunk) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMPLIES(a_commit_room, clock, reset, cmd.commit, sts.out_free, "commit while output register is full")
   `ASSERT_IMPLIES(a_commit_kind, clock, reset, cmd.commit, (sts.cur_cmd == CMD_ALLOC) || (sts.cur_cmd == CMD_FREE), "commit for an ignored command")

endmodule
